### sv/b64_pkg.sv
// Shared types, codes and character mapping functions for the Base64 stream codec.
package b64_pkg;

    // Configuration register indexes.
    localparam logic CFG_DIRECTION    = 1'b0;
    localparam logic CFG_URL_ALPHABET = 1'b1;

    // Direction codes.
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // Decoded symbol codes beyond the 64 alphabet values.
    localparam logic [6:0] CODE_PAD = 7'd64;
    localparam logic [6:0] CODE_BAD = 7'd65;

    // ASCII characters used by the mapping.
    localparam logic [7:0] CHR_PAD   = 8'h3D; // '='
    localparam logic [7:0] CHR_UC_A  = 8'h41; // 'A'
    localparam logic [7:0] CHR_UC_Z  = 8'h5A; // 'Z'
    localparam logic [7:0] CHR_LC_A  = 8'h61; // 'a'
    localparam logic [7:0] CHR_LC_Z  = 8'h7A; // 'z'
    localparam logic [7:0] CHR_ZERO  = 8'h30; // '0'
    localparam logic [7:0] CHR_NINE  = 8'h39; // '9'
    localparam logic [7:0] CHR_PLUS  = 8'h2B; // '+'
    localparam logic [7:0] CHR_SLASH = 8'h2F; // '/'
    localparam logic [7:0] CHR_MINUS = 8'h2D; // '-'
    localparam logic [7:0] CHR_UNDER = 8'h5F; // '_'

    // One accepted input beat.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_item;

    // All results caused by one input beat, entry 0 first.
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [1:0]      last_idx;
        logic            bad;
        logic            msg_end;
    } t_result_group;

    // Maps a 6-bit value to its alphabet character.
    function automatic logic [7:0] to_char(input logic [5:0] v, input logic url);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            return CHR_UC_A + w;
        end else if (v < 6'd52) begin
            return CHR_LC_A + w - 8'd26;
        end else if (v < 6'd62) begin
            return CHR_ZERO + w - 8'd52;
        end else if (v == 6'd62) begin
            return url ? CHR_MINUS : CHR_PLUS;
        end else begin
            return url ? CHR_UNDER : CHR_SLASH;
        end
    endfunction

    // Maps a character to its value, CODE_PAD for '=' or CODE_BAD otherwise.
    function automatic logic [6:0] from_char(input logic [7:0] c, input logic url);
        logic [7:0] d;
        d = 8'd0;
        if (c >= CHR_UC_A && c <= CHR_UC_Z) begin
            d = c - CHR_UC_A;
        end else if (c >= CHR_LC_A && c <= CHR_LC_Z) begin
            d = c - CHR_LC_A + 8'd26;
        end else if (c >= CHR_ZERO && c <= CHR_NINE) begin
            d = c - CHR_ZERO + 8'd52;
        end else if (c == CHR_PAD) begin
            d = {1'b0, CODE_PAD};
        end else if (url && c == CHR_MINUS) begin
            d = 8'd62;
        end else if (url && c == CHR_UNDER) begin
            d = 8'd63;
        end else if (!url && c == CHR_PLUS) begin
            d = 8'd62;
        end else if (!url && c == CHR_SLASH) begin
            d = 8'd63;
        end else begin
            d = {1'b0, CODE_BAD};
        end
        return d[6:0];
    endfunction

endpackage

### sv/b64_in_if.sv
// Input stream channel: one byte or character per beat with a last-of-message flag.
interface b64_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

### sv/b64_out_if.sv
// Output stream channel: one character or byte per beat with framing and error flags.
interface b64_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       message_end;
    logic       bad_input;

    modport source (output valid, output out_byte, output run_last, output message_end,
                    output bad_input, input ready);
    modport sink   (input valid, input out_byte, input run_last, input message_end,
                    input bad_input, output ready);
endinterface

### sv/b64_in_reg.sv
// Input register that holds one accepted beat until the group logic takes it.
module b64_in_reg
    import b64_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_take
);

    logic  r_valid;
    t_item r_item;

    // The register is free when empty or when its beat moves on this cycle.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

### sv/b64_group.sv
// Group state, configuration registers and the encode/decode logic for one beat.
module b64_group
    import b64_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic          i_cfg_data,
    input  t_item         i_item,
    input  logic          i_move,
    output logic          o_has_result,
    output t_result_group o_grp
);

    logic        r_dir;
    logic        r_url;
    logic [23:0] r_bits;
    logic [1:0]  r_count;
    logic [1:0]  r_pad;
    logic        r_err;

    logic [23:0] n_bits;
    logic [1:0]  n_count;
    logic [1:0]  n_pad;
    logic        n_err;

    logic [2:0]  cnt;
    logic [2:0]  enc_n;
    logic [23:0] enc_bits;
    logic [23:0] enc_shift;
    logic [6:0]  code;
    logic [5:0]  dec_val;
    logic [1:0]  pad_next;
    logic        err_next;
    logic [23:0] dec_bits;
    logic [1:0]  pad_cap;

    // Encode and decode paths for the beat in the input register.
    always_comb begin
        cnt       = {1'b0, r_count} + 3'd1;
        enc_n     = (cnt > 3'd3) ? 3'd3 : cnt;
        enc_bits  = {r_bits[15:0], i_item.data};
        code      = from_char(i_item.data, r_url);
        dec_val   = (code == CODE_PAD || code == CODE_BAD) ? 6'd0 : code[5:0];
        pad_next  = (code == CODE_PAD && r_pad != 2'd3) ? r_pad + 2'd1 : r_pad;
        err_next  = r_err || (code == CODE_BAD);
        dec_bits  = {r_bits[17:0], dec_val};
        pad_cap   = (pad_next > 2'd2) ? 2'd2 : pad_next;

        case (enc_n)
            3'd1:    enc_shift = {enc_bits[7:0], 16'h0000};
            3'd2:    enc_shift = {enc_bits[15:0], 8'h00};
            default: enc_shift = enc_bits;
        endcase

        o_has_result   = 1'b0;
        o_grp          = '0;
        o_grp.msg_end  = i_item.last;
        n_bits         = '0;
        n_count        = '0;
        n_pad          = '0;
        n_err          = 1'b0;

        if (r_dir == DIR_ENCODE) begin
            if (enc_n == 3'd3 || i_item.last) begin
                o_has_result   = 1'b1;
                o_grp.last_idx = 2'd3;
                for (int i = 0; i < 4; i++) begin
                    o_grp.data[i] = (3'(i) > enc_n) ? CHR_PAD
                                  : to_char(enc_shift[23 - 6 * i -: 6], r_url);
                end
            end else begin
                n_bits  = enc_bits;
                n_count = enc_n[1:0];
            end
        end else begin
            if (cnt < 3'd4) begin
                if (i_item.last) begin
                    // Message ended inside a quad: a single error result.
                    o_has_result   = 1'b1;
                    o_grp.bad      = 1'b1;
                    o_grp.last_idx = 2'd0;
                end else begin
                    n_bits  = dec_bits;
                    n_count = cnt[1:0];
                    n_pad   = pad_next;
                    n_err   = err_next;
                end
            end else begin
                o_has_result   = 1'b1;
                o_grp.bad      = err_next;
                o_grp.data[0]  = dec_bits[23:16];
                o_grp.data[1]  = dec_bits[15:8];
                o_grp.data[2]  = dec_bits[7:0];
                // Pads only shorten the final quad of a message.
                o_grp.last_idx = i_item.last ? 2'd2 - pad_cap : 2'd2;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= DIR_ENCODE;
            r_url <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DIRECTION:    r_dir <= i_cfg_data;
                CFG_URL_ALPHABET: r_url <= i_cfg_data;
                default:          r_dir <= r_dir;
            endcase
        end
    end

    // Group state; a direction write starts a fresh group.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits  <= '0;
            r_count <= '0;
            r_pad   <= '0;
            r_err   <= 1'b0;
        end else if (i_cfg_we && i_cfg_idx == CFG_DIRECTION) begin
            r_bits  <= '0;
            r_count <= '0;
            r_pad   <= '0;
            r_err   <= 1'b0;
        end else if (i_move) begin
            r_bits  <= n_bits;
            r_count <= n_count;
            r_pad   <= n_pad;
            r_err   <= n_err;
        end
    end

`ifndef NO_ASSERTIONS
    // An encode group never holds three bytes between beats.
    a_enc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dir == DIR_ENCODE |-> r_count != 2'd3)
        else $error("encode group count reached three");

    // Pad and error tracking stay clear while encoding.
    a_enc_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dir == DIR_ENCODE |-> (r_pad == 2'd0 && !r_err))
        else $error("decode tracking set in encode mode");

    // A direction write leaves an empty group.
    a_dir_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_idx == CFG_DIRECTION) |=> (r_count == 2'd0 && r_bits == 24'd0))
        else $error("group not cleared by direction write");
`endif

endmodule

### sv/b64_out_buf.sv
// Result register that holds one beat's result group and hands it out one beat at a time.
module b64_out_buf
    import b64_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  t_result_group i_grp,
    output logic          o_free,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_out_byte,
    output logic          o_run_last,
    output logic          o_message_end,
    output logic          o_bad_input
);

    logic          r_busy;
    logic [1:0]    r_idx;
    t_result_group r_grp;

    logic take;
    logic at_end;

    assign at_end        = (r_idx == r_grp.last_idx);
    assign take          = r_busy && i_ready;
    assign o_free        = !r_busy || (take && at_end);
    assign o_valid       = r_busy;
    assign o_out_byte    = r_grp.data[r_idx];
    assign o_run_last    = at_end;
    assign o_message_end = at_end && r_grp.msg_end;
    assign o_bad_input   = r_grp.bad;

    // Busy flag and read index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (take) begin
            r_busy <= !at_end;
            r_idx  <= at_end ? 2'd0 : r_idx + 2'd1;
        end
    end

    // Result group payload.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp <= i_grp;
        end
    end

`ifndef NO_ASSERTIONS
    // A new group is only loaded when the previous one is gone.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("result group overwritten");

    // The read index never passes the last entry.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_idx <= r_grp.last_idx)
        else $error("read index beyond group");

    // Taking the last entry without a new load empties the register.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && at_end && !i_load) |=> !r_busy)
        else $error("register not emptied after last beat");
`endif

endmodule

### sv/base64_stream_codec.sv
// Top level of the streaming Base64 encoder/decoder.
// Path: an input beat waits in the input register until its results can be loaded into the result register.
// Throughput: one input beat per cycle while the output keeps up; beats without results
// pass while the result register hands out one beat per cycle, so encoding runs at four
// output beats per three inputs. Reset: synchronous active-low i_rst_n clears the group,
// selects encode and the URL alphabet, and empties the input and result registers.
module base64_stream_codec
    import b64_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic       i_cfg_data,
    b64_in_if.sink     i_in_ch,
    b64_out_if.source  o_out_ch
);

    t_item         in_item;
    t_item         reg_item;
    logic          reg_valid;
    logic          move;
    logic          out_free;
    logic          has_result;
    t_result_group grp;

    assign in_item.data = i_in_ch.in_byte;
    assign in_item.last = i_in_ch.in_last;

    // A held beat moves on when it has no results or the result register can take them.
    assign move = reg_valid && (out_free || !has_result);

    b64_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_ch.valid),
        .o_ready (i_in_ch.ready),
        .i_item  (in_item),
        .o_valid (reg_valid),
        .o_item  (reg_item),
        .i_take  (move)
    );

    b64_group u_group (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_item       (reg_item),
        .i_move       (move),
        .o_has_result (has_result),
        .o_grp        (grp)
    );

    b64_out_buf u_out_buf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (move && has_result),
        .i_grp         (grp),
        .o_free        (out_free),
        .o_valid       (o_out_ch.valid),
        .i_ready       (o_out_ch.ready),
        .o_out_byte    (o_out_ch.out_byte),
        .o_run_last    (o_out_ch.run_last),
        .o_message_end (o_out_ch.message_end),
        .o_bad_input   (o_out_ch.bad_input)
    );

endmodule

### test/base64_stream_codec_tb.sv
// Testbench for the Base64 stream codec: directed and random beats checked against a predictor.
`timescale 1ns / 1ps

module base64_stream_codec_tb;
    import b64_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int DIRECTED_BEATS = 27;
    localparam int RANDOM_BEATS = 440;
    localparam int PHASE_BEATS = 60;

    // One result beat as it leaves the codec.
    typedef struct {
        logic [7:0] data;
        logic       run_last;
        logic       msg_end;
        logic       bad;
    } t_codec_beat;

    // Predicts the result beats of every accepted input beat and checks them in order.
    class codec_ledger;
        logic        dir;
        logic        url;
        logic [23:0] bits;
        int          count;
        int          pads;
        logic        err;
        int          errors;
        string       alpha;
        t_codec_beat owed[$];

        function new();
            alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789";
            errors = 0;
            dir = DIR_ENCODE;
            url = 1'b1;
            clear_group();
        endfunction

        function void clear_group();
            bits = '0;
            count = 0;
            pads = 0;
            err = 1'b0;
        endfunction

        // A direction write also drops any partial group.
        function void set_reg(logic idx, logic val);
            if (idx == CFG_DIRECTION) begin
                dir = val;
                clear_group();
            end else begin
                url = val;
            end
        endfunction

        function logic [7:0] symbol(logic [5:0] v);
            if (v < 6'd62) begin
                return alpha[int'(v)];
            end
            if (v == 6'd62) begin
                return url ? CHR_MINUS : CHR_PLUS;
            end
            return url ? CHR_UNDER : CHR_SLASH;
        endfunction

        // Reverse lookup by search over the current alphabet.
        function logic [6:0] value(logic [7:0] c);
            for (int k = 0; k < 64; k++) begin
                if (symbol(6'(k)) == c) begin
                    return 7'(k);
                end
            end
            if (c == CHR_PAD) begin
                return CODE_PAD;
            end
            return CODE_BAD;
        endfunction

        function void owe(logic [7:0] data, logic run_last, logic msg_end, logic bad);
            t_codec_beat beat;
            beat.data = data;
            beat.run_last = run_last;
            beat.msg_end = msg_end;
            beat.bad = bad;
            owed.push_back(beat);
        endfunction

        // Notes one accepted input beat and queues the results it causes.
        function void take_input(logic [7:0] b, logic last);
            int          n;
            int          nb;
            logic [23:0] sh;
            logic [7:0]  c;
            logic [6:0]  v;
            n = count + 1;
            if (dir == DIR_ENCODE) begin
                bits = {bits[15:0], b};
                if (n < 3 && !last) begin
                    count = n;
                    return;
                end
                // A short tail is zero-filled and the missing characters become pads.
                sh = bits << (8 * (3 - n));
                for (int i = 0; i < 4; i++) begin
                    c = (i > n) ? CHR_PAD : symbol(sh[23 - 6 * i -: 6]);
                    owe(c, i == 3, last && i == 3, 1'b0);
                end
            end else begin
                v = value(b);
                if (v == CODE_PAD) begin
                    v = '0;
                    if (pads < 3) begin
                        pads++;
                    end
                end else if (v == CODE_BAD) begin
                    v = '0;
                    err = 1'b1;
                end
                bits = {bits[17:0], v[5:0]};
                if (n < 4) begin
                    if (!last) begin
                        count = n;
                        return;
                    end
                    // The message ended inside a quad.
                    owe(8'h00, 1'b1, 1'b1, 1'b1);
                end else begin
                    // Pads only shorten the final quad of a message.
                    nb = last ? 3 - ((pads > 2) ? 2 : pads) : 3;
                    for (int i = 0; i < nb; i++) begin
                        owe(bits[23 - 8 * i -: 8], i == nb - 1, last && i == nb - 1, err);
                    end
                end
            end
            clear_group();
        endfunction

        function void field_check(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        function void flag_check(string name, logic want, logic got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch: expected %b, actual %b", $time, name, want, got);
            end
        endfunction

        // Compares one accepted result beat with the oldest expected one.
        function void match_output(logic [7:0] data, logic run_last, logic msg_end, logic bad);
            t_codec_beat want;
            if (owed.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat: expected none, actual %h", $time, data);
                return;
            end
            want = owed.pop_front();
            field_check("out_byte", want.data, data);
            flag_check("run_last", want.run_last, run_last);
            flag_check("message_end", want.msg_end, msg_end);
            flag_check("bad_input", want.bad, bad);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_idx;
    logic i_cfg_data;
    logic steady;
    int   beats_sent = 0;

    codec_ledger ledger = new();

    b64_in_if  in_ch ();
    b64_out_if out_ch ();

    base64_stream_codec dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // Result side: random back-pressure, and every accepted beat is checked.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= steady || ($urandom_range(0, 99) >= 23);
            if (out_ch.valid && out_ch.ready) begin
                ledger.match_output(out_ch.out_byte, out_ch.run_last, out_ch.message_end,
                                    out_ch.bad_input);
            end
        end
    end

    // Offers one input beat, possibly after a random gap, and waits for it to be taken.
    task automatic push_beat(logic [7:0] b, logic last);
        int gap;
        if (!steady && $urandom_range(0, 99) < 23) begin
            in_ch.valid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.in_last <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        ledger.take_input(b, last);
        beats_sent++;
    endtask

    // Holds off the sender until every expected beat has come and the pipeline is empty.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (ledger.owed.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write; the caller lowers the write enable.
    task automatic write_reg(logic idx, logic val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        ledger.set_reg(idx, val);
    endtask

    task automatic configure(logic dir, logic url);
        drain();
        write_reg(CFG_DIRECTION, dir);
        write_reg(CFG_URL_ALPHABET, url);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_encode_msg();
        int len;
        len = $urandom_range(1, 9);
        for (int k = 0; k < len; k++) begin
            push_beat(8'($urandom_range(0, 255)), k == len - 1);
        end
    endtask

    // Mostly well-formed quads with random content; the rest carries noise or is cut short.
    task automatic send_decode_msg();
        logic [7:0] msg[$];
        int         kind;
        int         quads;
        int         np;
        kind = $urandom_range(0, 99);
        quads = $urandom_range(1, 3);
        for (int k = 0; k < quads * 4; k++) begin
            msg.push_back(ledger.symbol(6'($urandom_range(0, 63))));
        end
        if (kind < 55) begin
            np = $urandom_range(0, 3);
            for (int k = 0; k < np; k++) begin
                msg[msg.size() - 1 - k] = CHR_PAD;
            end
        end else if (kind < 70) begin
            np = $urandom_range(1, 3);
            for (int k = 0; k < np; k++) begin
                msg[$urandom_range(0, msg.size() - 1)] = CHR_PAD;
            end
        end else if (kind < 85) begin
            np = $urandom_range(1, 2);
            for (int k = 0; k < np; k++) begin
                msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
            end
        end else begin
            np = $urandom_range(1, 3);
            repeat (np) void'(msg.pop_back());
        end
        for (int k = 0; k < msg.size(); k++) begin
            push_beat(msg[k], k == msg.size() - 1);
        end
    endtask

    // Stimulus: reset, directed cases, then random phases over all register settings.
    initial begin
        int phase;
        int phase_start;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_DIRECTION;
        i_cfg_data = DIR_ENCODE;
        in_ch.valid = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.in_last = 1'b0;
        out_ch.ready = 1'b0;
        steady = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Encode with the reset alphabet: a full group, a two-byte tail, a one-byte tail.
        push_beat(8'h00, 1'b0);
        push_beat(8'hFF, 1'b0);
        push_beat(8'hFB, 1'b0);
        push_beat(8'hFF, 1'b0);
        push_beat(8'hBF, 1'b1);
        push_beat(8'hF8, 1'b1);

        // Encode values 62 and 63 with the standard alphabet.
        configure(DIR_ENCODE, 1'b0);
        push_beat(8'hFB, 1'b0);
        push_beat(8'hFF, 1'b0);
        push_beat(8'hBF, 1'b1);

        // Decode: saturating pads, one pad, a pad and invalid characters in a
        // non-final quad, and a message that ends inside a quad.
        configure(DIR_DECODE, 1'b0);
        push_beat("Q", 1'b0);
        push_beat(CHR_PAD, 1'b0);
        push_beat(CHR_PAD, 1'b0);
        push_beat(CHR_PAD, 1'b1);
        push_beat("Q", 1'b0);
        push_beat("U", 1'b0);
        push_beat("I", 1'b0);
        push_beat(CHR_PAD, 1'b1);
        push_beat("A", 1'b0);
        push_beat(CHR_PAD, 1'b0);
        push_beat(8'hFF, 1'b0);
        push_beat(CHR_MINUS, 1'b0);
        push_beat("z", 1'b0);
        push_beat("z", 1'b1);

        // Decode with the URL alphabet.
        configure(DIR_DECODE, 1'b1);
        push_beat(CHR_MINUS, 1'b0);
        push_beat(CHR_UNDER, 1'b0);
        push_beat("9", 1'b0);
        push_beat("a", 1'b1);

        // Random phases; one runs without idling on either side.
        for (phase = 0; beats_sent < DIRECTED_BEATS + RANDOM_BEATS; phase++) begin
            configure(phase % 2 ? DIR_DECODE : DIR_ENCODE, 1'((phase / 2) % 2));
            steady <= (phase == 2);
            phase_start = beats_sent;
            while (beats_sent - phase_start < PHASE_BEATS) begin
                if (ledger.dir == DIR_ENCODE) begin
                    send_encode_msg();
                end else begin
                    send_decode_msg();
                end
                // Let the output run dry between messages in the middle of one phase.
                if (phase == 3 && beats_sent - phase_start >= PHASE_BEATS / 2
                        && beats_sent - phase_start < PHASE_BEATS / 2 + 12) begin
                    drain();
                end
            end
        end

        steady <= 1'b0;
        drain();
        if (ledger.errors == 0) begin
            $display("base64_stream_codec_tb: done, clean");
        end else begin
            $display("base64_stream_codec_tb: done, errors");
        end
        $finish;
    end

    // Watchdog against a stalled handshake.
    initial begin
        #2_000_000;
        $display("base64_stream_codec_tb: done, errors");
        $finish;
    end

endmodule
